// File: hdl/efjd_pkg.sv
// shared constants, item types and cell command types for the dispatcher
package efjd_pkg;

  localparam int MACHINES = 32;
  localparam int MIDX_W   = (MACHINES > 1) ? $clog2(MACHINES) : 1;
  localparam int CNT_W    = $clog2(MACHINES + 1);

  localparam int MODE_W   = 1;
  localparam int INDEX_W  = 5;
  localparam int DUR_W    = 16;
  localparam int TIME_W   = 32;
  localparam int SUM_W    = TIME_W + 1;
  localparam int COUNT_W  = 6;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  localparam logic [MODE_W-1:0] MODE_LOAD     = 1'b0;
  localparam logic [MODE_W-1:0] MODE_DISPATCH = 1'b1;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [INDEX_W-1:0] machine_index;
    logic [DUR_W-1:0]   service_time;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] chosen_machine;
    logic [TIME_W-1:0]  finish_time;
    logic               saturated;
  } out_item_t;

  // running minimum handed from cell to cell
  typedef struct packed {
    logic              vld;
    logic [CNT_W-1:0]  left;
    logic [SUM_W-1:0]  sum;
    logic [MIDX_W-1:0] idx;
  } token_t;

  // broadcast write command to all cells
  typedef struct packed {
    logic              load_en;
    logic              commit_en;
    logic [MIDX_W-1:0] idx;
    logic [DUR_W-1:0]  dur;
    logic [TIME_W-1:0] finish;
  } cell_cmd_t;

endpackage

// File: hdl/earliest_finish_job_dispatcher.sv
// top level: dispatch control, machine cell row and output register
//
// channel  direction  handshake                  payload
// in       input      in_valid_i / in_stall_o    in_data_i  (mode, machine_index, service_time)
// out      output     out_valid_o / out_stall_i  out_data_o (chosen_machine, finish_time, saturated)
// cfg      input      cfg_we_i                   cfg_data_i (machine_count)
//
// a load item is written into its cell and the next item is accepted right after it
// a dispatch item sends a minimum token along the row of
//   MACHINES cells one cell per cycle, then the chosen cell takes its new busy-until
// the result sits in an output register; a further dispatch only waits at its end
//   if that register is still full and stalled
// reset clears all service and busy-until times and sets machine_count to 1
module earliest_finish_job_dispatcher (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  efjd_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output efjd_pkg::out_item_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [efjd_pkg::COUNT_W-1:0]  cfg_data_i
);
  import efjd_pkg::*;

  // controller states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]         state_q, state_d;
  logic [COUNT_W-1:0] mcount_q;
  logic [CNT_W-1:0]   active_n;

  logic               in_acc;
  logic               load_acc;
  logic               disp_acc;
  logic               load_ok;

  token_t             chain [MACHINES+1];
  token_t             last_tok;
  cell_cmd_t          cmd;

  logic [TIME_W-1:0]  finish;
  out_item_t          res_new;
  out_item_t          res_q;
  logic               out_free;
  logic               out_valid_q;
  out_item_t          out_data_q;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcount_q <= COUNT_W'(1);
    end else if (cfg_we_i) begin
      mcount_q <= cfg_data_i;
    end
  end

  // zero count means one machine, counts beyond the row are clipped
  always_comb begin
    if (mcount_q == '0) begin
      active_n = CNT_W'(1);
    end else if (32'(mcount_q) > 32'(MACHINES)) begin
      active_n = CNT_W'(MACHINES);
    end else begin
      active_n = CNT_W'(mcount_q);
    end
  end

  // input handshake: items only taken while no dispatch is in flight
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign load_acc   = in_acc && (in_data_i.mode == MODE_LOAD);
  assign disp_acc   = in_acc && (in_data_i.mode == MODE_DISPATCH);
  // loads beyond the machine row are dropped
  assign load_ok    = 32'(in_data_i.machine_index) < 32'(MACHINES);

  // start token enters the first cell; all-ones sum loses to any real sum
  always_comb begin
    chain[0]      = '0;
    chain[0].vld  = disp_acc;
    chain[0].left = active_n;
    chain[0].sum  = '1;
    chain[0].idx  = '0;
  end

  // the row of machine cells
  for (genvar g = 0; g < MACHINES; g++) begin : g_cell
    efjd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (MIDX_W'(g)),
      .cmd_i      (cmd),
      .tok_i      (chain[g]),
      .tok_o      (chain[g+1])
    );
  end

  assign last_tok = chain[MACHINES];

  // saturate the winning sum to the time width
  assign finish = (last_tok.sum >= {1'b0, TIME_MAX}) ? TIME_MAX : last_tok.sum[TIME_W-1:0];

  always_comb begin
    res_new.chosen_machine = INDEX_W'(last_tok.idx);
    res_new.finish_time    = finish;
    res_new.saturated      = (finish == TIME_MAX);
  end

  // broadcast write: a load from the input, or the commit when the token leaves the row
  always_comb begin
    cmd.load_en   = load_acc && load_ok;
    cmd.commit_en = (state_q == ST_SCAN) && last_tok.vld;
    cmd.idx       = cmd.load_en ? MIDX_W'(in_data_i.machine_index) : last_tok.idx;
    cmd.dur       = in_data_i.service_time;
    cmd.finish    = finish;
  end

  // output register can take a new result this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (disp_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_tok.vld) begin
          state_d = out_free ? ST_IDLE : ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // parked result while the output register is still stalled
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && last_tok.vld) begin
      res_q <= res_new;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_SCAN) && last_tok.vld && out_free) begin
      out_valid_q <= 1'b1;
    end else if ((state_q == ST_HOLD) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_SCAN) && last_tok.vld && out_free) begin
      out_data_q <= res_new;
    end else if ((state_q == ST_HOLD) && out_free) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: hdl/efjd_cell.sv
// one machine cell: holds service and busy-until time, updates the running minimum
module efjd_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic [efjd_pkg::MIDX_W-1:0] cell_idx_i,
  input  efjd_pkg::cell_cmd_t       cmd_i,
  input  efjd_pkg::token_t          tok_i,
  output efjd_pkg::token_t          tok_o
);
  import efjd_pkg::*;

  logic [DUR_W-1:0]  dur_q;
  logic [TIME_W-1:0] busy_q;
  logic [SUM_W-1:0]  my_sum;
  logic              part;
  logic              take;
  token_t            tok_d;
  token_t            tok_q;

  assign my_sum = {1'b0, busy_q} + {{(SUM_W-DUR_W){1'b0}}, dur_q};
  assign part   = tok_i.vld && (tok_i.left != '0);
  assign take   = part && (my_sum < tok_i.sum);

  always_comb begin
    tok_d      = tok_i;
    tok_d.left = part ? tok_i.left - 1'b1 : tok_i.left;
    if (take) begin
      tok_d.sum = my_sum;
      tok_d.idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q  <= '0;
      busy_q <= '0;
    end else if (cmd_i.idx == cell_idx_i) begin
      if (cmd_i.load_en) begin
        dur_q  <= cmd_i.dur;
        busy_q <= '0;
      end else if (cmd_i.commit_en) begin
        busy_q <= cmd_i.finish;
      end
    end
  end

  assign tok_o = tok_q;

endmodule
